FILE: sv/bisv_pkg.sv
package bisv_pkg;

    // Fixed-point format of every coordinate and coefficient
    localparam int CW = 32;
    localparam int FB = 16;
    // Tolerance register width
    localparam int TW = 31;
    // Product, difference and magnitude widths
    localparam int PW = 2 * CW + 1;
    localparam int MW = 2 * CW;
    // Dividend: magnitude shifted by FB plus half the divisor
    localparam int NW = MW + FB + 1;
    // Width of the trial compares in the divider
    localparam int CMPW = (NW > MW + CW - 1) ? NW : MW + CW - 1;
    // Divider depth: overflow check plus one stage per quotient bit
    localparam int DIV_LAT = CW;
    // Configuration index width
    localparam int CFG_IW = 2;

    // Status codes
    localparam logic [2:0] ST_FOUND    = 3'd0;
    localparam logic [2:0] ST_MISSING  = 3'd1;
    localparam logic [2:0] ST_SAME     = 3'd2;
    localparam logic [2:0] ST_PARALLEL = 3'd3;
    localparam logic [2:0] ST_WRONG    = 3'd4;

    // Side tags
    localparam logic [1:0] SIDE_LEFT  = 2'd0;
    localparam logic [1:0] SIDE_RIGHT = 2'd1;
    localparam logic [1:0] SIDE_NONE  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IW-1:0] CFG_PARALLEL_TOL = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_EQUAL_TOL    = 2'd1;

    typedef struct packed {
        logic signed [CW-1:0] first_coef_x;
        logic signed [CW-1:0] first_coef_y;
        logic signed [CW-1:0] first_constant;
        logic signed [CW-1:0] second_coef_x;
        logic signed [CW-1:0] second_coef_y;
        logic signed [CW-1:0] second_constant;
        logic signed [CW-1:0] first_site_x;
        logic signed [CW-1:0] first_site_y;
        logic signed [CW-1:0] second_site_x;
        logic signed [CW-1:0] second_site_y;
        logic [1:0]           first_side;
        logic [1:0]           second_side;
    } in_word_t;

    typedef struct packed {
        logic [2:0]           status;
        logic signed [CW-1:0] vertex_x;
        logic signed [CW-1:0] vertex_y;
    } out_word_t;

    // Per-item control that rides alongside the arithmetic
    typedef struct packed {
        logic                 valid;
        logic [2:0]           status;
        logic                 low_right;
        logic signed [CW-1:0] low_sx;
        logic                 neg_x;
        logic                 neg_y;
    } ctrl_t;

    // Front-end result handed to the dividers
    typedef struct packed {
        ctrl_t            ctrl;
        logic [NW-1:0]    num_x;
        logic [NW-1:0]    num_y;
        logic [MW-1:0]    den;
    } front_t;

endpackage

FILE: sv/bisector_intersection_vertex.sv
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid / in_ready   | in_word   (bisv_pkg::in_word_t)
// out     | output    | out_valid / out_ready | out_word  (bisv_pkg::out_word_t)
// cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One word per cycle unless the output stalls; the path is 3 front stages, CW divider
// stages and 1 output register.
// Reset clears valid bits and sets both tolerances to 1.
// A waiting output word freezes the whole pipeline; nothing is lost or repeated.
module bisector_intersection_vertex (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  bisv_pkg::in_word_t            in_word,
    output logic                          out_valid,
    input  logic                          out_ready,
    output bisv_pkg::out_word_t           out_word,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bisv_pkg::CFG_IW-1:0]   cfg_index,
    input  logic [31:0]                   cfg_data
);

    localparam int CW  = bisv_pkg::CW;
    localparam int TW  = bisv_pkg::TW;
    localparam int LAT = bisv_pkg::DIV_LAT;

    logic en;
    logic out_valid_reg;
    bisv_pkg::out_word_t out_word_reg;

    // Global advance: hold everything while the output word waits
    assign en        = !(out_valid_reg && !out_ready);
    assign in_ready  = en;
    assign cfg_ready = 1'b1;

    // Tolerance registers
    logic [TW-1:0] par_tol_reg, eq_tol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            par_tol_reg <= {{(TW-1){1'b0}}, 1'b1};
            eq_tol_reg  <= {{(TW-1){1'b0}}, 1'b1};
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                bisv_pkg::CFG_PARALLEL_TOL: par_tol_reg <= cfg_data[TW-1:0];
                bisv_pkg::CFG_EQUAL_TOL:    eq_tol_reg  <= cfg_data[TW-1:0];
                default: ;
            endcase
        end
    end

    // Front end: products, differences, dividends
    bisv_pkg::front_t front;

    bisv_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_valid(in_valid),
        .in_word (in_word),
        .par_tol (par_tol_reg),
        .eq_tol  (eq_tol_reg),
        .front   (front)
    );

    // Two divider lanes
    logic [CW-2:0] qx, qy;
    logic          ovx, ovy;

    bisv_div u_div_x (
        .clk(clk), .en(en), .num(front.num_x), .den(front.den), .quo(qx), .ovf(ovx)
    );

    bisv_div u_div_y (
        .clk(clk), .en(en), .num(front.num_y), .den(front.den), .quo(qy), .ovf(ovy)
    );

    // Control delay line matching the divider latency
    bisv_pkg::ctrl_t ctrl_reg [0:LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
            begin
                ctrl_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            ctrl_reg[0] <= front.ctrl;
            for (int i = 1; i < LAT; i++)
            begin
                ctrl_reg[i] <= ctrl_reg[i-1];
            end
        end
    end

    // Sign, saturation, side test
    bisv_pkg::ctrl_t     c_last;
    logic signed [CW-1:0] vx, vy, qx_s, qy_s;
    logic                 right;
    bisv_pkg::out_word_t  word_next;

    localparam logic signed [CW-1:0] VMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] VMIN = {1'b1, {(CW-1){1'b0}}};

    always_comb
    begin
        c_last = ctrl_reg[LAT-1];
        qx_s   = {1'b0, qx};
        qy_s   = {1'b0, qy};
        vx = c_last.neg_x ? (ovx ? VMIN : -qx_s) : (ovx ? VMAX : qx_s);
        vy = c_last.neg_y ? (ovy ? VMIN : -qy_s) : (ovy ? VMAX : qy_s);
        right = vx >= c_last.low_sx;

        word_next          = '0;
        word_next.status   = c_last.status;
        if (c_last.status == bisv_pkg::ST_FOUND)
        begin
            if (right != c_last.low_right)
            begin
                word_next.status = bisv_pkg::ST_WRONG;
            end
            else
            begin
                word_next.vertex_x = vx;
                word_next.vertex_y = vy;
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= c_last.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_word_reg <= word_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

FILE: sv/bisv_front.sv
module bisv_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  bisv_pkg::in_word_t      in_word,
    input  logic [bisv_pkg::TW-1:0] par_tol,
    input  logic [bisv_pkg::TW-1:0] eq_tol,
    output bisv_pkg::front_t        front
);

    localparam int CW = bisv_pkg::CW;
    localparam int PW = bisv_pkg::PW;
    localparam int MW = bisv_pkg::MW;
    localparam int NW = bisv_pkg::NW;
    localparam int FB = bisv_pkg::FB;
    localparam int TW = bisv_pkg::TW;

    // ---------------- stage A: products and classification
    logic signed [2*CW-1:0] a1b2_reg, b1a2_reg, c1b2_reg, c2b1_reg, c2a1_reg, c1a2_reg;
    bisv_pkg::ctrl_t        ca_reg, ca_next;

    logic signed [CW:0]     dy;
    logic [CW:0]            dy_mag;
    logic                   first_low;

    always_comb
    begin
        dy     = {in_word.first_site_y[CW-1], in_word.first_site_y}
               - {in_word.second_site_y[CW-1], in_word.second_site_y};
        dy_mag = dy[CW] ? (~dy + 1'b1) : dy;
        first_low = (in_word.first_site_y < in_word.second_site_y) ||
                    (({{TW{1'b0}}, dy_mag} <= {{(CW+1){1'b0}}, eq_tol}) &&
                     (in_word.first_site_x < in_word.second_site_x));

        ca_next        = '0;
        ca_next.valid  = in_valid;
        ca_next.low_sx = first_low ? in_word.first_site_x : in_word.second_site_x;
        ca_next.low_right = first_low ? (in_word.first_side == bisv_pkg::SIDE_RIGHT)
                                      : (in_word.second_side == bisv_pkg::SIDE_RIGHT);
        if (in_word.first_side[1] || in_word.second_side[1])
        begin
            ca_next.status = bisv_pkg::ST_MISSING;
        end
        else if (in_word.first_site_x == in_word.second_site_x &&
                 in_word.first_site_y == in_word.second_site_y)
        begin
            ca_next.status = bisv_pkg::ST_SAME;
        end
        else
        begin
            ca_next.status = bisv_pkg::ST_FOUND;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ca_reg <= '0;
        end
        else if (en)
        begin
            ca_reg <= ca_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1b2_reg <= in_word.first_coef_x * in_word.second_coef_y;
            b1a2_reg <= in_word.first_coef_y * in_word.second_coef_x;
            c1b2_reg <= in_word.first_constant * in_word.second_coef_y;
            c2b1_reg <= in_word.second_constant * in_word.first_coef_y;
            c2a1_reg <= in_word.second_constant * in_word.first_coef_x;
            c1a2_reg <= in_word.first_constant * in_word.second_coef_x;
        end
    end

    // ---------------- stage B: determinant and numerators
    logic signed [PW-1:0] det_reg, xn_reg, yn_reg;
    bisv_pkg::ctrl_t      cb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cb_reg <= '0;
        end
        else if (en)
        begin
            cb_reg <= ca_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            det_reg <= {a1b2_reg[2*CW-1], a1b2_reg} - {b1a2_reg[2*CW-1], b1a2_reg};
            xn_reg  <= {c1b2_reg[2*CW-1], c1b2_reg} - {c2b1_reg[2*CW-1], c2b1_reg};
            yn_reg  <= {c2a1_reg[2*CW-1], c2a1_reg} - {c1a2_reg[2*CW-1], c1a2_reg};
        end
    end

    // ---------------- stage C: magnitudes, parallel test, dividends
    logic [PW-1:0]   det_abs, xn_abs, yn_abs;
    logic [MW-1:0]   det_mag, xn_mag, yn_mag;
    logic            parallel;
    bisv_pkg::ctrl_t cc_next;
    bisv_pkg::ctrl_t cc_reg;
    logic [NW-1:0]   nx_reg, ny_reg;
    logic [MW-1:0]   den_reg;

    always_comb
    begin
        det_abs = det_reg[PW-1] ? (~det_reg + 1'b1) : det_reg;
        xn_abs  = xn_reg[PW-1]  ? (~xn_reg + 1'b1)  : xn_reg;
        yn_abs  = yn_reg[PW-1]  ? (~yn_reg + 1'b1)  : yn_reg;
        det_mag = det_abs[MW-1:0];
        xn_mag  = xn_abs[MW-1:0];
        yn_mag  = yn_abs[MW-1:0];
        parallel = {{(TW+FB){1'b0}}, det_mag} <= {{MW{1'b0}}, par_tol, {FB{1'b0}}};

        cc_next       = cb_reg;
        cc_next.neg_x = xn_reg[PW-1] ^ det_reg[PW-1];
        cc_next.neg_y = yn_reg[PW-1] ^ det_reg[PW-1];
        if (cb_reg.status == bisv_pkg::ST_FOUND && parallel)
        begin
            cc_next.status = bisv_pkg::ST_PARALLEL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cc_reg <= '0;
        end
        else if (en)
        begin
            cc_reg <= cc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx_reg  <= {1'b0, xn_mag, {FB{1'b0}}} + {{(FB+2){1'b0}}, det_mag[MW-1:1]};
            ny_reg  <= {1'b0, yn_mag, {FB{1'b0}}} + {{(FB+2){1'b0}}, det_mag[MW-1:1]};
            den_reg <= det_mag;
        end
    end

    always_comb
    begin
        front.ctrl  = cc_reg;
        front.num_x = nx_reg;
        front.num_y = ny_reg;
        front.den   = den_reg;
    end

endmodule

FILE: sv/bisv_div.sv
module bisv_div (
    input  logic                      clk,
    input  logic                      en,
    input  logic [bisv_pkg::NW-1:0]   num,
    input  logic [bisv_pkg::MW-1:0]   den,
    output logic [bisv_pkg::CW-2:0]   quo,
    output logic                      ovf
);

    localparam int CW   = bisv_pkg::CW;
    localparam int NW   = bisv_pkg::NW;
    localparam int MW   = bisv_pkg::MW;
    localparam int CMPW = bisv_pkg::CMPW;
    localparam int LAT  = bisv_pkg::DIV_LAT;

    // One restoring step per stage, most significant quotient bit first
    logic [CMPW-1:0] rem_reg [0:LAT-1];
    logic [MW-1:0]   den_reg [0:LAT-1];
    logic [CW-2:0]   q_reg   [0:LAT-1];
    logic            ovf_reg [0:LAT-1];

    // Stage 0: quotient reaches the sign bit -> saturate
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= {{(CMPW-NW){1'b0}}, num};
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            ovf_reg[0] <= {{(CMPW-NW){1'b0}}, num} >= {den, {(CW-1){1'b0}}};
        end
    end

    genvar k;
    generate
        for (k = 1; k < LAT; k++)
        begin : g_step
            logic [CMPW-1:0] trial;
            logic            take;

            assign trial = {{(CMPW-MW){1'b0}}, den_reg[k-1]} << (LAT - 1 - k);
            assign take  = rem_reg[k-1] >= trial;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= take ? (rem_reg[k-1] - trial) : rem_reg[k-1];
                    den_reg[k] <= den_reg[k-1];
                    q_reg[k]   <= {q_reg[k-1][CW-3:0], take};
                    ovf_reg[k] <= ovf_reg[k-1];
                end
            end
        end
    endgenerate

    assign quo = q_reg[LAT-1];
    assign ovf = ovf_reg[LAT-1];

endmodule

FILE: sim/tb_bisector_intersection_vertex.sv
`timescale 1ns / 1ps

// Scoreboard: predicts each vertex query and checks results in order
class vertex_board;
    bisv_pkg::out_word_t pending[$];
    logic [30:0] par_tol;
    logic [30:0] eq_tol;
    int errors;
    int checked;
    int found_cnt;
    int reject_cnt;

    function new();
        par_tol = 31'd1;
        eq_tol = 31'd1;
        errors = 0;
        checked = 0;
        found_cnt = 0;
        reject_cnt = 0;
    endfunction

    // Round-to-nearest (ties away) fixed divide with saturation
    function logic signed [31:0] fix_div(logic signed [65:0] num, logic signed [65:0] den);
        logic [127:0] nm;
        logic [127:0] dm;
        logic [127:0] q;
        logic neg;
        nm = num < 0 ? -num : num;
        dm = den < 0 ? -den : den;
        neg = (num < 0) != (den < 0);
        q = ((nm << 16) + (dm >> 1)) / dm;
        if (neg)
        begin
            if (q >= 128'h8000_0000) return 32'sh8000_0000;
            return -$signed(q[31:0]);
        end
        if (q >= 128'h8000_0000) return 32'sh7fff_ffff;
        return q[31:0];
    endfunction

    function bisv_pkg::out_word_t solve_vertex(bisv_pkg::in_word_t w);
        bisv_pkg::out_word_t r;
        logic signed [65:0] det, xn, yn;
        logic signed [65:0] dy;
        logic [65:0] mag;
        logic first_low, right;
        logic signed [31:0] sx;
        logic [1:0] sd;
        r = '0;
        if (w.first_side >= bisv_pkg::SIDE_NONE || w.second_side >= bisv_pkg::SIDE_NONE)
        begin
            r.status = bisv_pkg::ST_MISSING;
            return r;
        end
        if (w.first_site_x == w.second_site_x && w.first_site_y == w.second_site_y)
        begin
            r.status = bisv_pkg::ST_SAME;
            return r;
        end
        det = 66'(w.first_coef_x) * 66'(w.second_coef_y)
            - 66'(w.first_coef_y) * 66'(w.second_coef_x);
        mag = det < 0 ? -det : det;
        if (mag <= (66'(par_tol) << 16))
        begin
            r.status = bisv_pkg::ST_PARALLEL;
            return r;
        end
        xn = 66'(w.first_constant) * 66'(w.second_coef_y)
           - 66'(w.second_constant) * 66'(w.first_coef_y);
        yn = 66'(w.second_constant) * 66'(w.first_coef_x)
           - 66'(w.first_constant) * 66'(w.second_coef_x);
        r.vertex_x = fix_div(xn, det);
        r.vertex_y = fix_div(yn, det);
        dy = 66'(w.first_site_y) - 66'(w.second_site_y);
        first_low = (w.first_site_y < w.second_site_y) ||
                    ((dy < 0 ? -dy : dy) <= 66'(eq_tol) &&
                     w.first_site_x < w.second_site_x);
        sx = first_low ? w.first_site_x : w.second_site_x;
        sd = first_low ? w.first_side : w.second_side;
        right = r.vertex_x >= sx;
        if ((right && sd == bisv_pkg::SIDE_LEFT) || (!right && sd == bisv_pkg::SIDE_RIGHT))
        begin
            r = '0;
            r.status = bisv_pkg::ST_WRONG;
        end
        return r;
    endfunction

    function void note_query(bisv_pkg::in_word_t w);
        pending.push_back(solve_vertex(w));
    endfunction

    function void check_result(bisv_pkg::out_word_t got);
        bisv_pkg::out_word_t exp_w;
        if (pending.size() == 0)
        begin
            $error("unexpected result word status=%0d", got.status);
            errors++;
            return;
        end
        exp_w = pending.pop_front();
        checked++;
        if (exp_w.status == bisv_pkg::ST_FOUND) found_cnt++;
        else reject_cnt++;
        if (got.status !== exp_w.status)
        begin
            $error("status expected %0d actual %0d", exp_w.status, got.status);
            errors++;
        end
        if (got.vertex_x !== exp_w.vertex_x)
        begin
            $error("vertex_x expected %h actual %h", exp_w.vertex_x, got.vertex_x);
            errors++;
        end
        if (got.vertex_y !== exp_w.vertex_y)
        begin
            $error("vertex_y expected %h actual %h", exp_w.vertex_y, got.vertex_y);
            errors++;
        end
    endfunction
endclass

module tb_bisector_intersection_vertex;

    localparam int LATENCY = 40;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    bisv_pkg::in_word_t in_word = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    bisv_pkg::out_word_t out_word;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [bisv_pkg::CFG_IW-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    vertex_board board = new();
    bit calm = 1'b0;
    bit hold_off = 1'b0;

    bisector_intersection_vertex DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
        .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Run limit
    initial
    begin
        #4ms;
        $display("TB_ERROR");
        $finish;
    end

    // Result side: random stalls, a long hold-off on request
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready) board.check_result(out_word);
            out_ready <= !hold_off && (calm || $urandom_range(99) >= 18);
        end
    end

    // One register write; cfg_valid then drops and the channel idles before the task returns
    task automatic cfg_write(logic [bisv_pkg::CFG_IW-1:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == bisv_pkg::CFG_PARALLEL_TOL) board.par_tol = val[30:0];
        else if (idx == bisv_pkg::CFG_EQUAL_TOL) board.eq_tol = val[30:0];
        @(posedge clk);
    endtask

    // Valid stays up between back-to-back words; it drops only on an idle cycle
    task automatic send_query(bisv_pkg::in_word_t w);
        while (!calm && $urandom_range(99) < 18)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word <= w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        board.note_query(w);
    endtask

    task automatic drain();
        int n;
        n = 0;
        in_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        while (n < LATENCY)
        begin
            @(posedge clk);
            n++;
        end
    endtask

    function automatic logic [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return $urandom_range(32'h0010_0000) - 32'h0008_0000;
            2: return $urandom_range(32'h0400_0000) - 32'h0200_0000;
            default: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
        endcase
    endfunction

    function automatic bisv_pkg::in_word_t rand_query();
        bisv_pkg::in_word_t w;
        int m;
        m = $urandom_range(9) < 7 ? 1 + $urandom_range(1) : ($urandom_range(4) == 0 ? 3 : 0);
        w.first_coef_x = rand_coord(m);
        w.first_coef_y = rand_coord(m);
        w.first_constant = rand_coord(m);
        w.second_coef_x = rand_coord(m);
        w.second_coef_y = rand_coord(m);
        w.second_constant = rand_coord(m);
        w.first_site_x = rand_coord(m);
        w.first_site_y = rand_coord(m);
        w.second_site_x = rand_coord(m);
        w.second_site_y = rand_coord(m);
        // Mostly real edges; some missing or the unused tag
        w.first_side = $urandom_range(19) == 0 ? 2'($urandom_range(3)) : 2'($urandom_range(1));
        w.second_side = $urandom_range(19) == 0 ? 2'($urandom_range(3)) : 2'($urandom_range(1));
        case ($urandom_range(15))
            0: w.second_site_x = w.first_site_x;
            1:
            begin
                w.second_site_x = w.first_site_x;
                w.second_site_y = w.first_site_y;
            end
            2: w.second_site_y = w.first_site_y + $urandom_range(3) - 1;
            3:
            begin
                w.second_coef_x = w.first_coef_x;
                w.second_coef_y = w.first_coef_y;
            end
            default: ;
        endcase
        return w;
    endfunction

    initial
    begin
        bisv_pkg::in_word_t w;
        logic [31:0] par_set[4];
        logic [31:0] eq_set[4];
        int ph;
        par_set = '{32'd1, 32'd0, 32'h7fff_ffff, 32'h0000_0100};
        eq_set = '{32'd1, 32'h7fff_ffff, 32'd0, 32'h0001_0000};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every status, tag values, field extremes
        calm = 1'b1;
        w = '0;
        w.first_coef_x = 32'h0001_0000; w.second_coef_y = 32'h0001_0000;
        w.first_constant = 32'h0002_0000; w.second_constant = 32'h0003_0000;
        w.first_site_x = 32'h0001_0000; w.second_site_y = 32'h0005_0000;
        send_query(w);                                  // wrong side: first lower, vertex right, tag left
        w.first_side = bisv_pkg::SIDE_RIGHT; send_query(w);
        w.first_side = bisv_pkg::SIDE_NONE; send_query(w);   // missing edge
        w.first_side = 2'd3; send_query(w);             // unused tag
        w.first_side = bisv_pkg::SIDE_LEFT; w.second_side = 2'd3; send_query(w);
        w.second_side = bisv_pkg::SIDE_LEFT;
        w.second_site_x = w.first_site_x; w.second_site_y = w.first_site_y;
        send_query(w);                                  // same site
        w.second_site_y = 32'h0005_0000;
        w.second_coef_y = 32'h0000_0000; send_query(w); // parallel
        w.second_coef_y = 32'h0000_0001; send_query(w); // tiny det
        w.first_coef_x = 32'h8000_0000; w.first_coef_y = 32'h8000_0000;
        w.first_constant = 32'h7fff_ffff; w.second_coef_x = 32'h7fff_ffff;
        w.second_coef_y = 32'h8000_0000; w.second_constant = 32'h8000_0000;
        send_query(w);
        w.first_site_x = 32'h8000_0000; w.first_site_y = 32'h7fff_ffff;
        w.second_site_x = 32'h7fff_ffff; w.second_site_y = 32'h8000_0000;
        send_query(w);
        w.first_side = bisv_pkg::SIDE_RIGHT; w.second_side = bisv_pkg::SIDE_RIGHT;
        send_query(w);
        w.first_coef_x = 32'h0000_0001; w.first_coef_y = 32'h0000_0000;
        w.second_coef_x = 32'h0000_0000; w.second_coef_y = 32'h0000_0001;
        w.first_constant = 32'h7fff_ffff; w.second_constant = 32'h8000_0000;
        send_query(w);                                  // det of 1: parallel under the reset tolerance
        w.first_site_y = 32'h0000_0000; w.second_site_y = 32'h0000_0001;
        w.first_site_x = 32'h0000_0005; w.second_site_x = 32'h0000_0002;
        send_query(w);                                  // y within tolerance
        w.first_side = bisv_pkg::SIDE_LEFT; send_query(w);
        w = '1; w.first_side = bisv_pkg::SIDE_LEFT; w.second_side = bisv_pkg::SIDE_RIGHT;
        send_query(w);
        calm = 1'b0;
        drain();

        // Random phases across tolerance settings
        for (ph = 0; ph < 4; ph++)
        begin
            cfg_write(bisv_pkg::CFG_PARALLEL_TOL, par_set[ph]);
            cfg_write(bisv_pkg::CFG_EQUAL_TOL, eq_set[ph]);
            if (ph == 1) cfg_write(2'd2, 32'h0000_1234);
            if (ph == 3) cfg_write(2'd3, 32'hffff_ffff);
            calm = (ph == 2);
            for (int i = 0; i < 250; i++)
            begin
                if (ph == 1 && i == 20)
                begin
                    fork
                        begin
                            int c;
                            hold_off = 1'b1;
                            for (c = 0; c < 150; c++) @(posedge clk);
                            hold_off = 1'b0;
                        end
                    join_none
                end
                send_query(rand_query());
            end
            drain();
        end

        $display("Checked %0d results: %0d vertices, %0d rejects, over four tolerance settings.",
                 board.checked, board.found_cnt, board.reject_cnt);
        if (board.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
